// ===== hdl/tpm_pkg.sv =====
// shared types and constants of the task period and load monitor
`default_nettype none

package tpm_pkg;

   typedef enum logic [1:0] {
      OP_RUN_IN  = 2'd0,
      OP_RUN_OUT = 2'd1,
      OP_TICK    = 2'd2,
      OP_READ    = 2'd3
   } tpm_op_type;

   typedef struct packed {
      tpm_op_type  op;
      logic [31:0] delta;
      logic [3:0]  sel;
      logic        first;
      logic        drop;
   } tpm_item_type;

   typedef logic [5:0][31:0] tpm_ext_type;

   localparam int unsigned EXT_MAX_HOUR = 0;
   localparam int unsigned EXT_MIN_HOUR = 1;
   localparam int unsigned EXT_MAX_DAY  = 2;
   localparam int unsigned EXT_MIN_DAY  = 3;
   localparam int unsigned EXT_MAX_ALL  = 4;
   localparam int unsigned EXT_MIN_ALL  = 5;

   localparam logic [3:0] STAT_LOAD_BASE = 4'd6;
   localparam logic [3:0] STAT_END       = 4'd12;

endpackage

`default_nettype wire

// ===== hdl/tpm_front.sv =====
// front end: takes events, forms the delta and classifies each item
`default_nettype none

module tpm_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic [31:0]          req_timestamp_us,
   input  wire logic [3:0]           req_stat_select,
   input  wire logic [31:0]          ignore_limit_us,
   input  wire logic                 queue_full,
   output logic                      push,
   output tpm_pkg::tpm_item_type     push_item
);
   import tpm_pkg::*;

   logic [31:0] last_in_ff;
   logic [31:0] last_in_in;
   logic [31:0] delta;
   tpm_op_type  op;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign op        = tpm_op_type'(req_operation);
   assign delta     = req_timestamp_us - last_in_ff;

   always_comb begin
      push_item.op    = op;
      push_item.delta = delta;
      push_item.sel   = req_stat_select;
      push_item.first = (last_in_ff == 32'd0);
      push_item.drop  = (delta > ignore_limit_us);
      last_in_in      = last_in_ff;
      if (push && (op == OP_RUN_IN)) begin
         last_in_in = req_timestamp_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_in_ff <= 32'd0;
      end else begin
         last_in_ff <= last_in_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tpm_queue.sv =====
// short queue of classified items between front and back
`default_nettype none

module tpm_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tpm_pkg::tpm_item_type push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output tpm_pkg::tpm_item_type     pop_item
);
   import tpm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   tpm_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tpm_back.sv =====
// back end: statistics, window timers and the result register
`default_nettype none

module tpm_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire tpm_pkg::tpm_item_type item,
   output logic                      pop,
   input  wire logic [31:0]          hour_window_ms,
   input  wire logic [31:0]          day_window_ms,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [31:0]               rsp_period_us,
   output logic [31:0]               rsp_load_us,
   output logic [31:0]               rsp_run_count,
   output logic                      rsp_in_task,
   output logic [31:0]               rsp_stat_value
);
   import tpm_pkg::*;

   function automatic tpm_ext_type tpm_fold(tpm_ext_type e, logic [31:0] d);
      tpm_ext_type r;
      r = e;
      if (d > r[EXT_MAX_HOUR]) begin
         r[EXT_MAX_HOUR] = d;
         if (r[EXT_MAX_DAY] < d) begin
            r[EXT_MAX_DAY] = d;
            if (r[EXT_MAX_ALL] < d) begin
               r[EXT_MAX_ALL] = d;
            end
         end
      end
      if (d < r[EXT_MIN_HOUR]) begin
         r[EXT_MIN_HOUR] = d;
         if (r[EXT_MIN_DAY] > d) begin
            r[EXT_MIN_DAY] = d;
            if ((r[EXT_MIN_ALL] > d) || (r[EXT_MIN_ALL] == 32'd0)) begin
               r[EXT_MIN_ALL] = d;
            end
         end else if (r[EXT_MIN_DAY] == 32'd0) begin
            r[EXT_MIN_DAY] = d;
         end
      end else if (r[EXT_MIN_HOUR] == 32'd0) begin
         r[EXT_MIN_HOUR] = d;
      end
      return r;
   endfunction

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] stat_ff;
   logic [31:0] stat_in;
   logic [31:0] period_ff;
   logic [31:0] period_in;
   logic [31:0] load_ff;
   logic [31:0] load_in;
   logic [31:0] run_count_ff;
   logic [31:0] run_count_in;
   logic        running_ff;
   logic        running_in;
   tpm_ext_type pext_ff;
   tpm_ext_type pext_in;
   tpm_ext_type lext_ff;
   tpm_ext_type lext_in;
   logic [31:0] hour_rem_ff;
   logic [31:0] hour_rem_in;
   logic [31:0] day_rem_ff;
   logic [31:0] day_rem_in;
   logic        hour_armed_ff;
   logic        hour_armed_in;
   logic        day_armed_ff;
   logic        day_armed_in;

   assign pop            = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_period_us  = period_ff;
   assign rsp_load_us    = load_ff;
   assign rsp_run_count  = run_count_ff;
   assign rsp_in_task    = running_ff;
   assign rsp_stat_value = stat_ff;

   always_comb begin
      tpm_ext_type pt;
      tpm_ext_type lt;
      logic [3:0]  lsel;
      pt            = pext_ff;
      lt            = lext_ff;
      lsel          = item.sel - STAT_LOAD_BASE;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      stat_in       = stat_ff;
      period_in     = period_ff;
      load_in       = load_ff;
      run_count_in  = run_count_ff;
      running_in    = running_ff;
      pext_in       = pext_ff;
      lext_in       = lext_ff;
      hour_rem_in   = hour_rem_ff;
      day_rem_in    = day_rem_ff;
      hour_armed_in = hour_armed_ff;
      day_armed_in  = day_armed_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         stat_in      = 32'd0;
         case (item.op)
            OP_RUN_IN: begin
               run_count_in = run_count_ff + 32'd1;
               if (!item.first && !item.drop) begin
                  period_in = item.delta;
                  if (hour_armed_ff && (hour_rem_ff == 32'd0)) begin
                     hour_rem_in      = hour_window_ms;
                     pt[EXT_MAX_HOUR] = item.delta;
                     pt[EXT_MIN_HOUR] = item.delta;
                     lt[EXT_MAX_HOUR] = 32'd0;
                     lt[EXT_MIN_HOUR] = '1;
                     if (day_armed_ff && (day_rem_ff == 32'd0)) begin
                        day_rem_in      = day_window_ms;
                        pt[EXT_MAX_DAY] = item.delta;
                        pt[EXT_MIN_DAY] = item.delta;
                        lt[EXT_MAX_DAY] = 32'd0;
                        lt[EXT_MIN_DAY] = '1;
                     end else if (!day_armed_ff) begin
                        day_rem_in   = day_window_ms;
                        day_armed_in = 1'b1;
                     end
                  end else if (!hour_armed_ff) begin
                     hour_rem_in   = hour_window_ms;
                     hour_armed_in = 1'b1;
                  end
                  pext_in    = tpm_fold(pt, item.delta);
                  lext_in    = lt;
                  running_in = 1'b1;
               end
            end
            OP_RUN_OUT: begin
               if (!item.drop) begin
                  load_in    = item.delta;
                  lext_in    = tpm_fold(lext_ff, item.delta);
                  running_in = 1'b0;
               end
            end
            OP_TICK: begin
               if (hour_armed_ff && (hour_rem_ff != 32'd0)) begin
                  hour_rem_in = hour_rem_ff - 32'd1;
               end
               if (day_armed_ff && (day_rem_ff != 32'd0)) begin
                  day_rem_in = day_rem_ff - 32'd1;
               end
            end
            OP_READ: begin
               if (item.sel < STAT_LOAD_BASE) begin
                  stat_in = pext_ff[item.sel[2:0]];
               end else if (item.sel < STAT_END) begin
                  stat_in = lext_ff[lsel[2:0]];
               end
            end
            default: begin
               stat_in = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         period_ff     <= 32'd0;
         load_ff       <= 32'd0;
         run_count_ff  <= 32'd0;
         running_ff    <= 1'b0;
         pext_ff       <= '0;
         lext_ff       <= '0;
         hour_rem_ff   <= 32'd0;
         day_rem_ff    <= 32'd0;
         hour_armed_ff <= 1'b0;
         day_armed_ff  <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         period_ff     <= period_in;
         load_ff       <= load_in;
         run_count_ff  <= run_count_in;
         running_ff    <= running_in;
         pext_ff       <= pext_in;
         lext_ff       <= lext_in;
         hour_rem_ff   <= hour_rem_in;
         day_rem_ff    <= day_rem_in;
         hour_armed_ff <= hour_armed_in;
         day_armed_ff  <= day_armed_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
   end

`ifndef ASSERT_OFF
   a_day_needs_hour: assert property (@(posedge clock) disable iff (reset)
      day_armed_ff |-> hour_armed_ff)
      else $error("day timer armed without hour timer");

   a_hour_stays_armed: assert property (@(posedge clock) disable iff (reset)
      hour_armed_ff |=> hour_armed_ff)
      else $error("hour timer disarmed");

   a_run_out_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && (item.op == OP_RUN_OUT) && !item.drop) |=> !running_ff)
      else $error("accepted run-out left task running");
`endif

endmodule

`default_nettype wire

// ===== hdl/task_period_load_monitor_core.sv =====
// top level of the task period and load monitor with its control registers
`default_nettype none

// Takes one event transfer per clock cycle while req_stall is low and returns
// exactly one result transfer per event, in order. An accepted event is held in
// the queue slot and then in the back's result registers; the front computes the
// delta from the last run-in timestamp and the back updates the nested hour, day
// and all-time extremes and window timers as it takes an item, so the sustained
// rate is one event per cycle while the result side does not stall. QUEUE_DEPTH
// events are absorbed while the result side stalls before req_stall rises.
// Registers at byte addresses 0, 4 and 8 hold the ignore limit and the hour and
// day window lengths; write them only while idle.
module task_period_load_monitor_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_timestamp_us,
   input  wire logic [3:0]  req_stat_select,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_period_us,
   output logic [31:0]      rsp_load_us,
   output logic [31:0]      rsp_run_count,
   output logic             rsp_in_task,
   output logic [31:0]      rsp_stat_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import tpm_pkg::*;

   localparam logic [3:0]  ADDR_IGNORE_LIMIT = 4'h0;
   localparam logic [3:0]  ADDR_HOUR_WINDOW  = 4'h4;
   localparam logic [3:0]  ADDR_DAY_WINDOW   = 4'h8;
   localparam logic [31:0] RST_IGNORE_LIMIT  = 32'd90000000;
   localparam logic [31:0] RST_HOUR_WINDOW   = 32'd3600000;
   localparam logic [31:0] RST_DAY_WINDOW    = 32'd86400000;

   logic [31:0]  ignore_limit_ff;
   logic [31:0]  hour_window_ff;
   logic [31:0]  day_window_ff;
   logic         csr_write;
   logic         queue_full;
   logic         push;
   tpm_item_type push_item;
   logic         pop;
   logic         pop_valid;
   tpm_item_type pop_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_limit_ff <= RST_IGNORE_LIMIT;
         hour_window_ff  <= RST_HOUR_WINDOW;
         day_window_ff   <= RST_DAY_WINDOW;
      end else if (csr_write) begin
         case (paddr)
            ADDR_IGNORE_LIMIT: ignore_limit_ff <= pwdata;
            ADDR_HOUR_WINDOW:  hour_window_ff  <= pwdata;
            ADDR_DAY_WINDOW:   day_window_ff   <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr)
         ADDR_IGNORE_LIMIT: prdata = ignore_limit_ff;
         ADDR_HOUR_WINDOW:  prdata = hour_window_ff;
         ADDR_DAY_WINDOW:   prdata = day_window_ff;
         default:           prdata = 32'd0;
      endcase
   end

   tpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_timestamp_us (req_timestamp_us),
      .req_stat_select  (req_stat_select),
      .ignore_limit_us  (ignore_limit_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   tpm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   tpm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (pop_valid),
      .item           (pop_item),
      .pop            (pop),
      .hour_window_ms (hour_window_ff),
      .day_window_ms  (day_window_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_period_us  (rsp_period_us),
      .rsp_load_us    (rsp_load_us),
      .rsp_run_count  (rsp_run_count),
      .rsp_in_task    (rsp_in_task),
      .rsp_stat_value (rsp_stat_value)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench for the task period and load monitor: queued events, predicted results, checks
module tb;
   import tpm_pkg::*;

   localparam logic [3:0] ADDR_IGNORE_LIMIT = 4'd0;
   localparam logic [3:0] ADDR_HOUR_WINDOW  = 4'd4;
   localparam logic [3:0] ADDR_DAY_WINDOW   = 4'd8;

   typedef struct {
      tpm_op_type  op;
      logic [31:0] ts;
      logic [3:0]  sel;
   } task_event_type;

   typedef struct {
      logic [31:0] period_us;
      logic [31:0] load_us;
      logic [31:0] run_count;
      logic        in_task;
      logic [31:0] stat_value;
   } snapshot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = 2'd0;
   logic [31:0] req_timestamp_us = 32'd0;
   logic [3:0]  req_stat_select = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_period_us;
   logic [31:0] rsp_load_us;
   logic [31:0] rsp_run_count;
   logic        rsp_in_task;
   logic [31:0] rsp_stat_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   task_period_load_monitor_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_timestamp_us(req_timestamp_us),
      .req_stat_select(req_stat_select),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_period_us(rsp_period_us),
      .rsp_load_us(rsp_load_us),
      .rsp_run_count(rsp_run_count),
      .rsp_in_task(rsp_in_task),
      .rsp_stat_value(rsp_stat_value),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // mirrored registers and monitor state
   logic [31:0] lim_us, hour_len, day_len;
   logic [31:0] prev_in_ts, prev_out_ts, runs, cur_period, cur_load;
   logic [31:0] hour_left, day_left;
   logic        hour_on, day_on, busy;
   tpm_ext_type per_ext, load_ext;

   task_event_type pending_events[$];
   snapshot_type   expected_snapshots[$];
   int unsigned fail_count = 0;
   logic [31:0] cycle_count = 32'd0;
   logic        req_taken = 1'b0;
   logic        drain_hold = 1'b0;
   logic [31:0] ts_now;
   wire         calm = (cycle_count[11:9] == 3'd3);

   function automatic tpm_ext_type merge_delta(tpm_ext_type e, logic [31:0] d);
      if (d > e[EXT_MAX_HOUR]) begin
         e[EXT_MAX_HOUR] = d;
         if (e[EXT_MAX_DAY] < d) begin
            e[EXT_MAX_DAY] = d;
            if (e[EXT_MAX_ALL] < d) e[EXT_MAX_ALL] = d;
         end
      end
      if (d < e[EXT_MIN_HOUR]) begin
         e[EXT_MIN_HOUR] = d;
         if (e[EXT_MIN_DAY] > d) begin
            e[EXT_MIN_DAY] = d;
            if (e[EXT_MIN_ALL] > d || e[EXT_MIN_ALL] == 32'd0) e[EXT_MIN_ALL] = d;
         end else if (e[EXT_MIN_DAY] == 32'd0) begin
            e[EXT_MIN_DAY] = d;
         end
      end else if (e[EXT_MIN_HOUR] == 32'd0) begin
         e[EXT_MIN_HOUR] = d;
      end
      return e;
   endfunction

   function automatic snapshot_type advance_monitor(tpm_op_type op, logic [31:0] ts,
                                                    logic [3:0] sel);
      snapshot_type s;
      logic [31:0]  d;
      s.stat_value = 32'd0;
      d = ts - prev_in_ts;
      case (op)
         OP_RUN_IN: begin
            runs = runs + 32'd1;
            if (prev_in_ts == 32'd0) begin
               prev_in_ts = ts;
            end else begin
               prev_in_ts = ts;
               if (d <= lim_us) begin
                  cur_period = d;
                  if (hour_on && hour_left == 32'd0) begin
                     hour_left = hour_len;
                     per_ext[EXT_MAX_HOUR] = d;
                     per_ext[EXT_MIN_HOUR] = d;
                     load_ext[EXT_MAX_HOUR] = 32'd0;
                     load_ext[EXT_MIN_HOUR] = 32'hFFFF_FFFF;
                     if (day_on && day_left == 32'd0) begin
                        day_left = day_len;
                        per_ext[EXT_MAX_DAY] = d;
                        per_ext[EXT_MIN_DAY] = d;
                        load_ext[EXT_MAX_DAY] = 32'd0;
                        load_ext[EXT_MIN_DAY] = 32'hFFFF_FFFF;
                     end else if (!day_on) begin
                        day_left = day_len;
                        day_on = 1'b1;
                     end
                  end else if (!hour_on) begin
                     hour_left = hour_len;
                     hour_on = 1'b1;
                  end
                  per_ext = merge_delta(per_ext, d);
                  busy = 1'b1;
               end
            end
         end
         OP_RUN_OUT: begin
            if (d <= lim_us) begin
               prev_out_ts = ts;
               cur_load = d;
               load_ext = merge_delta(load_ext, d);
               busy = 1'b0;
            end
         end
         OP_TICK: begin
            if (hour_on && hour_left != 32'd0) hour_left = hour_left - 32'd1;
            if (day_on && day_left != 32'd0) day_left = day_left - 32'd1;
         end
         default: begin
            if (sel < STAT_LOAD_BASE) s.stat_value = per_ext[sel];
            else if (sel < STAT_END) s.stat_value = load_ext[sel - STAT_LOAD_BASE];
         end
      endcase
      s.period_us = cur_period;
      s.load_us = cur_load;
      s.run_count = runs;
      s.in_task = busy;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (fail_count < 40) $display("mismatch %s: got %h, expected %h", what, got, want);
      fail_count++;
   endtask

   task automatic add_event(tpm_op_type op, logic [31:0] ts, logic [3:0] sel);
      task_event_type e;
      e.op = op;
      e.ts = ts;
      e.sel = sel;
      pending_events.push_back(e);
   endtask

   // mostly run-in/run-out cycles with ticks and reads, plus some random noise
   task automatic add_traffic(int count, int unsigned step_max);
      task_event_type e;
      int unsigned    r;
      repeat (count) begin
         r = $urandom_range(99);
         e.ts = $urandom;
         e.sel = $urandom_range(15);
         if (r < 30) begin
            e.op = OP_RUN_IN;
            ts_now = ts_now + $urandom_range(step_max);
            e.ts = ts_now;
         end else if (r < 55) begin
            e.op = OP_RUN_OUT;
            ts_now = ts_now + $urandom_range(step_max);
            e.ts = ts_now;
         end else if (r < 75) begin
            e.op = OP_TICK;
         end else if (r < 92) begin
            e.op = OP_READ;
            if ($urandom_range(3) != 0) e.sel = $urandom_range(11);
         end else begin
            e.op = tpm_op_type'($urandom_range(3));
         end
         pending_events.push_back(e);
      end
   endtask

   task automatic wait_for_drain();
      while (pending_events.size() != 0 || req_valid || expected_snapshots.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [3:0] addr, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (addr)
         ADDR_IGNORE_LIMIT: lim_us = value;
         ADDR_HOUR_WINDOW:  hour_len = value;
         ADDR_DAY_WINDOW:   day_len = value;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // event driver
   always @(negedge clock) begin : drive_events
      task_event_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (drain_hold) begin
            if (expected_snapshots.size() == 0) drain_hold = 1'b0;
            req_valid <= 1'b0;
         end else if (pending_events.size() == 0 || (!calm && $urandom_range(99) < 31)) begin
            req_valid <= 1'b0;
         end else begin
            e = pending_events.pop_front();
            req_valid <= 1'b1;
            req_operation <= e.op;
            req_timestamp_us <= e.ts;
            req_stat_select <= e.sel;
            if ($urandom_range(99) == 0) drain_hold = 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 31);
   end

   // transfer monitor and checker
   always @(posedge clock) begin : watch_transfers
      snapshot_type want;
      cycle_count <= cycle_count + 32'd1;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_snapshots.size() == 0) begin
               report_mismatch("result transfer with nothing expected", rsp_period_us, 32'd0);
            end else begin
               want = expected_snapshots.pop_front();
               if (rsp_period_us !== want.period_us)
                  report_mismatch("period_us", rsp_period_us, want.period_us);
               if (rsp_load_us !== want.load_us)
                  report_mismatch("load_us", rsp_load_us, want.load_us);
               if (rsp_run_count !== want.run_count)
                  report_mismatch("run_count", rsp_run_count, want.run_count);
               if (rsp_in_task !== want.in_task)
                  report_mismatch("in_task", {31'd0, rsp_in_task}, {31'd0, want.in_task});
               if (rsp_stat_value !== want.stat_value)
                  report_mismatch("stat_value", rsp_stat_value, want.stat_value);
            end
         end
         if (req_valid && !req_stall)
            expected_snapshots.push_back(advance_monitor(tpm_op_type'(req_operation),
                                                         req_timestamp_us, req_stat_select));
      end
   end

   initial begin
      lim_us = 32'd90000000;
      hour_len = 32'd3600000;
      day_len = 32'd86400000;
      prev_in_ts = 32'd0;
      prev_out_ts = 32'd0;
      runs = 32'd0;
      cur_period = 32'd0;
      cur_load = 32'd0;
      hour_left = 32'd0;
      day_left = 32'd0;
      hour_on = 1'b0;
      day_on = 1'b0;
      busy = 1'b0;
      per_ext = '0;
      load_ext = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short windows so hour and day restarts happen, default ignore limit
      write_register(ADDR_HOUR_WINDOW, 32'd3);
      write_register(ADDR_DAY_WINDOW, 32'd2);

      add_event(OP_READ, 32'h0000_0000, 4'd12);
      add_event(OP_READ, 32'hFFFF_FFFF, 4'd15);
      add_event(OP_TICK, 32'hFFFF_FFFF, 4'd0);
      add_event(OP_RUN_OUT, 32'hFFFF_FFFF, 4'd0);
      add_event(OP_RUN_IN, 32'd0, 4'd0);
      add_event(OP_RUN_IN, 32'd1000, 4'd0);
      add_event(OP_RUN_OUT, 32'd1250, 4'd0);
      add_event(OP_RUN_IN, 32'd3000, 4'd0);
      add_event(OP_READ, 32'd0, 4'd0);
      add_event(OP_RUN_OUT, 32'd3000, 4'd0);
      add_event(OP_READ, 32'd0, 4'd7);
      repeat (3) add_event(OP_TICK, 32'd0, 4'd0);
      add_event(OP_RUN_IN, 32'd3500, 4'd0);
      add_event(OP_RUN_OUT, 32'd3600, 4'd0);
      repeat (3) add_event(OP_TICK, 32'd0, 4'd0);
      // just over the limit is dropped, exactly at the limit is kept
      add_event(OP_RUN_IN, 32'd90003601, 4'd0);
      add_event(OP_RUN_IN, 32'd180003601, 4'd0);
      add_event(OP_RUN_OUT, 32'd180003600, 4'd0);
      // wrap of the microsecond counter
      add_event(OP_RUN_IN, 32'hFFFF_FF00, 4'd0);
      add_event(OP_RUN_IN, 32'h0000_0050, 4'd0);
      add_event(OP_READ, 32'd0, 4'd5);
      add_event(OP_READ, 32'd0, 4'd6);
      add_event(OP_READ, 32'd0, 4'd11);
      ts_now = 32'h0000_0050;
      add_traffic(400, 2000);
      wait_for_drain();

      // zero windows restart on every accepted run-in
      write_register(ADDR_IGNORE_LIMIT, 32'd5000);
      write_register(ADDR_HOUR_WINDOW, 32'd0);
      write_register(ADDR_DAY_WINDOW, 32'd0);
      add_traffic(300, 8000);
      wait_for_drain();

      write_register(ADDR_IGNORE_LIMIT, 32'd0);
      add_traffic(250, 1);
      wait_for_drain();

      write_register(ADDR_IGNORE_LIMIT, $urandom_range(100000, 100));
      write_register(ADDR_HOUR_WINDOW, $urandom_range(12, 1));
      write_register(ADDR_DAY_WINDOW, $urandom_range(6, 1));
      add_traffic(500, lim_us + lim_us / 2);
      wait_for_drain();

      write_register(ADDR_IGNORE_LIMIT, 32'hFFFF_FFFF);
      write_register(ADDR_HOUR_WINDOW, 32'hFFFF_FFFF);
      write_register(ADDR_DAY_WINDOW, 32'hFFFF_FFFF);
      add_traffic(400, 100000);
      wait_for_drain();

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
